/* rtl/core/sorted_priority_queue_macros.svh */
// assertion macros shared by the sorted priority queue rtl
`ifndef SORTED_PRIORITY_QUEUE_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_MACROS_SVH

// expression holds at every edge outside reset
`define SPQ_ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed: expression does not hold");

// consequent holds in the same cycle as the antecedent
`define SPQ_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// consequent holds in the cycle after the antecedent
`define SPQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

/* rtl/core/spq_pkg.sv */
// types and constants of the sorted priority queue
package spq_pkg;

   localparam int CAPACITY = 16;
   localparam int VALUE_W  = 32;
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int COUNT_PORT_W = 5;
   localparam int STATUS_W = 2;

   localparam logic [VALUE_W-1:0] NONE_VALUE = {VALUE_W{1'b1}};

   typedef enum logic [0:0] {
      ACTION_PUSH = 1'b0,
      ACTION_POP  = 1'b1
   } action_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] value;
      logic signed [VALUE_W-1:0] priority_key;
   } spq_entry_type;

   typedef struct packed {
      logic                      push_en;
      logic                      pop_en;
      logic signed [VALUE_W-1:0] new_value;
      logic signed [VALUE_W-1:0] new_priority;
   } spq_ctrl_type;

endpackage

/* rtl/core/spq_cell.sv */
// one cell of the sorted chain: holds an entry, shifts left on pop, right on insert
module spq_cell
   import spq_pkg::*;
(
   input  logic          clock,
   input  spq_ctrl_type  ctrl,
   input  logic          occupied,
   input  spq_entry_type left_entry,
   input  logic          left_after,
   input  spq_entry_type right_entry,
   output spq_entry_type entry,
   output spq_entry_type next_entry,
   output logic          after
);

   spq_entry_type entry_ff;
   spq_entry_type entry_in;

   // the new item goes in front of this cell when it is empty or strictly larger
   assign after = !occupied || (entry_ff.priority_key > ctrl.new_priority);

   always_comb begin
      entry_in = entry_ff;
      if (ctrl.pop_en) begin
         entry_in = right_entry;
      end else if (ctrl.push_en && after) begin
         if (left_after) begin
            entry_in = left_entry;
         end else begin
            entry_in.value        = ctrl.new_value;
            entry_in.priority_key = ctrl.new_priority;
         end
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry      = entry_ff;
   assign next_entry = entry_in;

endmodule

/* rtl/core/sorted_priority_queue.sv */
// sorted priority queue: a chain of CAPACITY cells, all compared with a push at once
// the result strobe is registered: it rises in the cycle after start is taken
// throughput: one push or pop per cycle; busy stays low, every cell updates at the same edge
// the receiver cannot stall: each result is shown for exactly one cycle
// reset clears the entry count and the result strobe; cell contents stay undefined
`include "sorted_priority_queue_macros.svh"

module sorted_priority_queue
   import spq_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic                     req_action,
   input  logic signed [VALUE_W-1:0] req_item_value,
   input  logic signed [VALUE_W-1:0] req_item_priority,
   output logic                     rsp_valid,
   output logic signed [VALUE_W-1:0] rsp_popped_value,
   output logic signed [VALUE_W-1:0] rsp_head_value,
   output logic [STATUS_W-1:0]      rsp_status,
   output logic [COUNT_PORT_W-1:0]  rsp_entry_count
);

   logic [CNT_W-1:0]          count_ff, count_in;
   logic                      rsp_valid_ff;
   logic [VALUE_W-1:0]        rsp_popped_value_ff, rsp_popped_value_in;
   logic [VALUE_W-1:0]        rsp_head_value_ff, rsp_head_value_in;
   status_type                rsp_status_ff, rsp_status_in;
   logic [COUNT_PORT_W-1:0]   rsp_entry_count_ff, rsp_entry_count_in;

   logic                      accept;
   logic                      is_pop;
   logic                      is_empty;
   logic                      is_full;
   spq_ctrl_type              ctrl;

   spq_entry_type             entries      [CAPACITY];
   spq_entry_type             next_entries [CAPACITY];
   spq_entry_type             left_entries [CAPACITY];
   spq_entry_type             right_entries[CAPACITY];
   logic [CAPACITY-1:0]       after;
   logic [CAPACITY-1:0]       left_after;
   logic [CAPACITY-1:0]       occupied;

   assign busy     = 1'b0;
   assign accept   = start && !busy;
   assign is_pop   = (req_action == ACTION_POP);
   assign is_empty = (count_ff == '0);
   assign is_full  = (count_ff == CNT_W'(CAPACITY));

   always_comb begin
      ctrl.push_en      = accept && !is_pop && !is_full;
      ctrl.pop_en       = accept && is_pop && !is_empty;
      ctrl.new_value    = req_item_value;
      ctrl.new_priority = req_item_priority;
   end

   // neighbour wiring of the chain; the first cell sees a blank left, the last sees itself on the right
   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         if (i == 0) begin
            left_entries[i] = '0;
            left_after[i]   = 1'b0;
         end else begin
            left_entries[i] = entries[i-1];
            left_after[i]   = after[i-1];
         end
         if (i == CAPACITY - 1) begin
            right_entries[i] = entries[i];
         end else begin
            right_entries[i] = entries[i+1];
         end
      end
   end

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      assign occupied[i] = (CNT_W'(i) < count_ff);

      spq_cell u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .occupied    (occupied[i]),
         .left_entry  (left_entries[i]),
         .left_after  (left_after[i]),
         .right_entry (right_entries[i]),
         .entry       (entries[i]),
         .next_entry  (next_entries[i]),
         .after       (after[i])
      );
   end

   always_comb begin
      count_in = count_ff;
      if (ctrl.push_en) begin
         count_in = count_ff + CNT_W'(1);
      end else if (ctrl.pop_en) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_comb begin
      rsp_popped_value_in = NONE_VALUE;
      rsp_status_in       = STATUS_OK;
      if (ctrl.pop_en) begin
         rsp_popped_value_in = entries[0].value;
      end
      if (accept && is_pop && is_empty) begin
         rsp_status_in = STATUS_EMPTY;
      end else if (accept && !is_pop && is_full) begin
         rsp_status_in = STATUS_FULL;
      end
      rsp_head_value_in  = (count_in == '0) ? NONE_VALUE : next_entries[0].value;
      rsp_entry_count_in = COUNT_PORT_W'(count_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      rsp_popped_value_ff <= rsp_popped_value_in;
      rsp_head_value_ff   <= rsp_head_value_in;
      rsp_status_ff       <= rsp_status_in;
      rsp_entry_count_ff  <= rsp_entry_count_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_popped_value = rsp_popped_value_ff;
   assign rsp_head_value   = rsp_head_value_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_entry_count  = rsp_entry_count_ff;

   `SPQ_ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= CNT_W'(CAPACITY))
   `SPQ_ASSERT_NEXT(a_strobe_follows_start, clock, reset, accept, rsp_valid)
   `SPQ_ASSERT_IMPLY(a_empty_means_zero, clock, reset,
      rsp_valid && rsp_status == STATUS_EMPTY, rsp_entry_count == '0)
   `SPQ_ASSERT_IMPLY(a_full_means_capacity, clock, reset,
      rsp_valid && rsp_status == STATUS_FULL,
      rsp_entry_count == COUNT_PORT_W'(CAPACITY))

endmodule

/* dv/testbench.sv */
// self-checking testbench for the sorted priority queue against a shadow queue
module testbench;
   import spq_pkg::*;

   typedef struct {
      action_type                action;
      logic signed [VALUE_W-1:0] value;
      logic signed [VALUE_W-1:0] prio;
   } queue_cmd_type;

   typedef struct {
      logic signed [VALUE_W-1:0] popped;
      logic signed [VALUE_W-1:0] head;
      status_type                status;
      logic [COUNT_PORT_W-1:0]   count;
   } queue_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic req_action = 1'b0;
   logic signed [VALUE_W-1:0] req_item_value = '0;
   logic signed [VALUE_W-1:0] req_item_priority = '0;
   logic rsp_valid;
   logic signed [VALUE_W-1:0] rsp_popped_value;
   logic signed [VALUE_W-1:0] rsp_head_value;
   logic [STATUS_W-1:0] rsp_status;
   logic [COUNT_PORT_W-1:0] rsp_entry_count;

   // shadow copy of the sorted entries
   logic signed [VALUE_W-1:0] shadow_value [CAPACITY];
   logic signed [VALUE_W-1:0] shadow_prio [CAPACITY];
   int shadow_count = 0;

   queue_cmd_type pending_cmds[$];
   queue_rsp_type awaited_rsps[$];
   queue_rsp_type due;
   queue_cmd_type taken_cmd;
   queue_cmd_type next_cmd;
   bit item_taken = 0;
   bit steady_run = 0;
   int gap_left = 0;
   int mismatches = 0;

   sorted_priority_queue dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_action(req_action),
      .req_item_value(req_item_value),
      .req_item_priority(req_item_priority),
      .rsp_valid(rsp_valid),
      .rsp_popped_value(rsp_popped_value),
      .rsp_head_value(rsp_head_value),
      .rsp_status(rsp_status),
      .rsp_entry_count(rsp_entry_count)
   );

   always #1 clock = ~clock;

   // applies one item to the shadow queue and returns the result it must give
   function automatic queue_rsp_type shadow_apply(queue_cmd_type cmd);
      queue_rsp_type res;
      int pos;
      int i;
      res.popped = NONE_VALUE;
      res.status = STATUS_OK;
      if (cmd.action == ACTION_PUSH) begin
         if (shadow_count >= CAPACITY) begin
            res.status = STATUS_FULL;
         end else begin
            // new entry goes after every entry of lower or equal priority
            pos = 0;
            while (pos < shadow_count && shadow_prio[pos] <= cmd.prio) pos++;
            for (i = shadow_count; i > pos; i--) begin
               shadow_value[i] = shadow_value[i-1];
               shadow_prio[i] = shadow_prio[i-1];
            end
            shadow_value[pos] = cmd.value;
            shadow_prio[pos] = cmd.prio;
            shadow_count++;
         end
      end else begin
         if (shadow_count == 0) begin
            res.status = STATUS_EMPTY;
         end else begin
            res.popped = shadow_value[0];
            for (i = 1; i < shadow_count; i++) begin
               shadow_value[i-1] = shadow_value[i];
               shadow_prio[i-1] = shadow_prio[i];
            end
            shadow_count--;
         end
      end
      res.head = (shadow_count > 0) ? shadow_value[0] : NONE_VALUE;
      res.count = shadow_count[COUNT_PORT_W-1:0];
      return res;
   endfunction

   task automatic add_cmd(action_type action, logic signed [VALUE_W-1:0] value,
                          logic signed [VALUE_W-1:0] prio);
      queue_cmd_type cmd;
      cmd.action = action;
      cmd.value = value;
      cmd.prio = prio;
      pending_cmds.push_back(cmd);
   endtask

   // driver: new item or idle cycle at each falling edge
   always @(negedge clock) begin
      if (!reset && (!start || item_taken)) begin
         item_taken = 0;
         if (gap_left > 0) begin
            gap_left--;
            start <= 1'b0;
         end else if (pending_cmds.size() > 0) begin
            next_cmd = pending_cmds.pop_front();
            req_action <= next_cmd.action;
            req_item_value <= next_cmd.value;
            req_item_priority <= next_cmd.prio;
            start <= 1'b1;
            if ($urandom_range(0, 149) == 0) steady_run = !steady_run;
            if (steady_run) begin
               gap_left = 0;
            end else begin
               case ($urandom_range(0, 19))
                  0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10: gap_left = 0;
                  11, 12, 13, 14, 15, 16, 17, 18: gap_left = $urandom_range(1, 3);
                  default: gap_left = $urandom_range(8, 40);
               endcase
            end
         end else begin
            start <= 1'b0;
         end
      end
   end

   // monitor: checks each result strobe and predicts each item taken
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid) begin
            if (awaited_rsps.size() == 0) begin
               if (mismatches < 10)
                  $display("unexpected result: popped %0d head %0d status %0d count %0d",
                           rsp_popped_value, rsp_head_value, rsp_status, rsp_entry_count);
               mismatches++;
            end else begin
               due = awaited_rsps.pop_front();
               if (rsp_popped_value !== due.popped || rsp_head_value !== due.head ||
                   rsp_status !== due.status || rsp_entry_count !== due.count) begin
                  if (mismatches < 10)
                     $display("mismatch: popped %0d/%0d head %0d/%0d status %0d/%0d count %0d/%0d",
                              due.popped, rsp_popped_value, due.head, rsp_head_value,
                              due.status, rsp_status, due.count, rsp_entry_count);
                  mismatches++;
               end
            end
         end
         if (start && !busy) begin
            taken_cmd.action = action_type'(req_action);
            taken_cmd.value = req_item_value;
            taken_cmd.prio = req_item_priority;
            awaited_rsps.push_back(shadow_apply(taken_cmd));
            item_taken = 1;
         end
      end
   end

   initial begin
      int n;
      int k;
      int phase_left;
      int fill_bias;
      logic signed [VALUE_W-1:0] v;
      logic signed [VALUE_W-1:0] p;

      // directed: empty pop, extremes, ties, real -1 data, fill to full, full push
      add_cmd(ACTION_POP, 32'h7fff_ffff, 32'h8000_0000);
      add_cmd(ACTION_PUSH, 32'h7fff_ffff, 32'h7fff_ffff);
      add_cmd(ACTION_PUSH, 32'h8000_0000, 32'h8000_0000);
      add_cmd(ACTION_PUSH, NONE_VALUE, 32'sd0);
      add_cmd(ACTION_PUSH, 32'sd5, 32'sd0);
      add_cmd(ACTION_PUSH, 32'sd6, 32'sd0);
      add_cmd(ACTION_POP, 32'h8000_0000, 32'h7fff_ffff);
      add_cmd(ACTION_POP, '0, '0);
      for (n = 0; n < CAPACITY - 3; n++) add_cmd(ACTION_PUSH, n, (n % 3) - 1);
      add_cmd(ACTION_PUSH, 32'sd77, 32'h8000_0000);
      add_cmd(ACTION_PUSH, NONE_VALUE, NONE_VALUE);
      add_cmd(ACTION_POP, NONE_VALUE, NONE_VALUE);

      // random: phases leaning to fill, to drain, or balanced
      phase_left = 0;
      fill_bias = 50;
      for (n = 0; n < 1200; n++) begin
         if (phase_left == 0) begin
            phase_left = $urandom_range(20, 60);
            case ($urandom_range(0, 2))
               0: fill_bias = 80;
               1: fill_bias = 20;
               default: fill_bias = 50;
            endcase
         end
         phase_left--;
         v = ($urandom_range(0, 15) == 0) ? NONE_VALUE : $urandom;
         case ($urandom_range(0, 3))
            0: p = $urandom_range(0, 8) - 4;
            1: begin
               case ($urandom_range(0, 3))
                  0: p = 32'h8000_0000;
                  1: p = 32'h7fff_ffff;
                  2: p = '0;
                  default: p = NONE_VALUE;
               endcase
            end
            default: p = $urandom;
         endcase
         if ($urandom_range(1, 100) <= fill_bias) add_cmd(ACTION_PUSH, v, p);
         else add_cmd(ACTION_POP, $urandom, $urandom);
      end

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      wait (pending_cmds.size() == 0 && !start);
      for (k = 0; k < 200 && awaited_rsps.size() > 0; k++) @(posedge clock);
      repeat (4) @(posedge clock);
      mismatches += awaited_rsps.size();
      if (mismatches == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

/* sim.f */
+incdir+rtl/core
rtl/core/spq_pkg.sv
rtl/core/spq_cell.sv
rtl/core/sorted_priority_queue.sv
dv/testbench.sv
